@@ rtl/tvbb_pkg.sv @@
package tvbb_pkg;

  // Model-space coordinate, signed Q8.8.
  typedef logic signed [15:0] coord_t;
  // World-space coordinate, signed Q16.8.
  typedef logic signed [23:0] world_t;
  // Box size along one axis, unsigned Q16.8.
  typedef logic [23:0] extent_t;
  // Four packed signed Q8.8 coefficients, the linear terms low and the translation high.
  typedef logic [63:0] coef_t;
  // Exact transform sum before the Q16.8 shift.
  typedef logic signed [33:0] wsum_t;

  // Configuration register indexes.
  localparam logic [1:0] CfgCoefX = 2'd0;
  localparam logic [1:0] CfgCoefY = 2'd1;
  localparam logic [1:0] CfgCoefZ = 2'd2;

  // Identity matrix after reset (1.0 is 256 on the diagonal).
  localparam coef_t CoefXReset = 64'd256;
  localparam coef_t CoefYReset = 64'd16777216;
  localparam coef_t CoefZReset = 64'd1099511627776;

  // Saturation bounds of a world coordinate.
  localparam wsum_t SatHi = 34'sd8388607;
  localparam wsum_t SatLo = -34'sd8388608;

  // Shift a Q16.16 sum down to Q16.8 with floor rounding, then clamp to 24 bits.
  function automatic world_t sat_world(input wsum_t s);
    wsum_t sh;
    sh = s >>> 8;
    if (sh > SatHi) begin
      return SatHi[23:0];
    end else if (sh < SatLo) begin
      return SatLo[23:0];
    end
    return sh[23:0];
  endfunction

endpackage

@@ rtl/tvbb_if.sv @@
// Vertex stream: one model-space point per word.
interface tvbb_vertex_if import tvbb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t vertex_z;
  logic   last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  output last_vertex, input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                input last_vertex, output ready);
endinterface

// Box stream: one bounding box per word.
interface tvbb_box_if import tvbb_pkg::*; ();
  logic    valid;
  logic    ready;
  world_t  min_x;
  world_t  min_y;
  world_t  min_z;
  world_t  max_x;
  world_t  max_y;
  world_t  max_z;
  world_t  center_x;
  world_t  center_y;
  world_t  center_z;
  extent_t extent_x;
  extent_t extent_y;
  extent_t extent_z;

  modport source (output valid, output min_x, output min_y, output min_z,
                  output max_x, output max_y, output max_z,
                  output center_x, output center_y, output center_z,
                  output extent_x, output extent_y, output extent_z, input ready);
  modport sink (input valid, input min_x, input min_y, input min_z,
                input max_x, input max_y, input max_z,
                input center_x, input center_y, input center_z,
                input extent_x, input extent_y, input extent_z, output ready);
endinterface

@@ rtl/transformed_vertex_bounding_box_top.sv @@
// The box of a pass is captured with its last vertex and then registered at the output.
// Throughput: one vertex word per cycle; the five register stages (input, products,
// sum and clamp, min/max fold, output) all advance together and stall only while
// the output word is held by the sink.
// Reset: asynchronous, active low; clears valid bits, the open pass and loads the
// identity matrix.
module transformed_vertex_bounding_box_top import tvbb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  tvbb_vertex_if.sink         vertex_i,
  tvbb_box_if.source          box_o
);

  logic  adv;
  coef_t coef_q [3];

  // Stage 0: input registers.
  logic   v0_q, last0_q;
  coord_t pt0_q [3];

  // Stage 1: products.
  logic               v1_q, last1_q;
  logic signed [31:0] prod_q [3][3];

  // Stage 2: world coordinates.
  logic   v2_q, last2_q;
  world_t w2_q [3];

  // Stage 3: running box and captured box.
  logic   started_q;
  world_t lo_q [3];
  world_t hi_q [3];
  logic   v3_q;
  world_t blo_q [3];
  world_t bhi_q [3];
  world_t lo_d [3];
  world_t hi_d [3];

  // Output register.
  logic    ov_q;
  world_t  omin_q [3];
  world_t  omax_q [3];
  world_t  ocen_q [3];
  extent_t oext_q [3];

  // The whole pipeline moves unless a finished word waits at the output.
  assign adv = !ov_q || box_o.ready;
  assign vertex_i.ready = adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= CoefXReset;
      coef_q[1] <= CoefYReset;
      coef_q[2] <= CoefZReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCoefX: coef_q[0] <= cfg_data_i;
        CfgCoefY: coef_q[1] <= cfg_data_i;
        CfgCoefZ: coef_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v0_q <= vertex_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q && last2_q;
      ov_q <= v3_q;
    end
  end

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt0_q[0] <= vertex_i.vertex_x;
      pt0_q[1] <= vertex_i.vertex_y;
      pt0_q[2] <= vertex_i.vertex_z;
      last0_q  <= vertex_i.last_vertex;
    end
  end

  // Nine 16x16 products: prod_q[axis][k] is coordinate k times its coefficient.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      last1_q <= last0_q;
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[a][k] <= 32'(pt0_q[k]) * 32'($signed(coef_q[a][16*k +: 16]));
        end
      end
    end
  end

  // Sum with the translation, floor to Q16.8 and clamp.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      last2_q <= last1_q;
      for (int a = 0; a < 3; a++) begin
        w2_q[a] <= sat_world(34'(prod_q[a][0]) + 34'(prod_q[a][1]) + 34'(prod_q[a][2])
                             + (34'($signed(coef_q[a][63:48])) <<< 8));
      end
    end
  end

  // Fold the point into the box; the first vertex of a pass sets both corners.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!started_q) begin
        lo_d[a] = w2_q[a];
        hi_d[a] = w2_q[a];
      end else begin
        lo_d[a] = (w2_q[a] < lo_q[a]) ? w2_q[a] : lo_q[a];
        hi_d[a] = (w2_q[a] > hi_q[a]) ? w2_q[a] : hi_q[a];
      end
    end
  end

  // Running box state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= '0;
        hi_q[a] <= '0;
      end
    end else if (adv && v2_q) begin
      started_q <= !last2_q;
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= lo_d[a];
        hi_q[a] <= hi_d[a];
      end
    end
  end

  // Capture the finished box on the last vertex.
  always_ff @(posedge clk_i) begin
    if (adv && v2_q && last2_q) begin
      for (int a = 0; a < 3; a++) begin
        blo_q[a] <= lo_d[a];
        bhi_q[a] <= hi_d[a];
      end
    end
  end

  // Output word: corners, floored center and extent.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [24:0] csum;
        csum      = 25'(blo_q[a]) + 25'(bhi_q[a]);
        omin_q[a] <= blo_q[a];
        omax_q[a] <= bhi_q[a];
        ocen_q[a] <= csum[24:1];
        oext_q[a] <= 24'(bhi_q[a] - blo_q[a]);
      end
    end
  end

  assign box_o.valid    = ov_q;
  assign box_o.min_x    = omin_q[0];
  assign box_o.min_y    = omin_q[1];
  assign box_o.min_z    = omin_q[2];
  assign box_o.max_x    = omax_q[0];
  assign box_o.max_y    = omax_q[1];
  assign box_o.max_z    = omax_q[2];
  assign box_o.center_x = ocen_q[0];
  assign box_o.center_y = ocen_q[1];
  assign box_o.center_z = ocen_q[2];
  assign box_o.extent_x = oext_q[0];
  assign box_o.extent_y = oext_q[1];
  assign box_o.extent_z = oext_q[2];

endmodule
